FILE: rtl/mcpg_pkg.sv
// Shared types and constants for the midpoint circle point generator.
// Used by mcpg_walk, mcpg_emit and midpoint_circle_point_generator.
`timescale 1ns / 1ps

package mcpg_pkg;

   // Fixed field widths
   localparam int CENTER_W = 16;
   localparam int PIX_W    = 17;
   localparam int IDX_W    = 3;

   // Action codes on the request word
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Index of the eighth point of a step
   localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

   // Handoff from the walk to the emitter
   typedef struct packed {
      logic load;   // a step word was taken and needs output
      logic done;   // the step found no more points
   } job_ctl_type;

endpackage

FILE: rtl/mcpg_walk.sv
// Walk state of the midpoint circle: center, column, row, decision, running.
// Starts a walk on a start word and computes one step per accepted step word; depends on mcpg_pkg.
`timescale 1ns / 1ps

module mcpg_walk #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    take,
   input  logic                                    action,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    center_x,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    center_y,
   input  logic        [RADIUS_BITS-1:0]           radius,
   output mcpg_pkg::job_ctl_type                   job_ctl,
   output logic signed [mcpg_pkg::CENTER_W-1:0]    job_cx,
   output logic signed [mcpg_pkg::CENTER_W-1:0]    job_cy,
   output logic        [RADIUS_BITS:0]             job_col,
   output logic signed [RADIUS_BITS:0]             job_row
);

   localparam int CW = RADIUS_BITS + 1;
   localparam int DW = RADIUS_BITS + 4;
   localparam int SW = RADIUS_BITS + 3;

   logic signed [mcpg_pkg::CENTER_W-1:0] cx_ff, cx_in;
   logic signed [mcpg_pkg::CENTER_W-1:0] cy_ff, cy_in;
   logic        [CW-1:0]                 column_ff, column_in;
   logic signed [CW-1:0]                 row_ff, row_in;
   logic signed [DW-1:0]                 decision_ff, decision_in;
   logic                                 running_ff, running_in;

   logic        [CW-1:0] r_ext;
   logic signed [SW-1:0] gap;
   logic                 finish;
   logic                 dec_pos;
   logic signed [CW-1:0] row_next;
   logic signed [DW-1:0] dec_mid;
   logic signed [DW-1:0] dec_next;

   // Step arithmetic: end test, row move, decision update
   always_comb begin
      r_ext    = CW'(radius);
      gap      = $signed({2'b00, column_ff}) + SW'(row_ff);
      finish   = !running_ff || !gap[SW-1];
      dec_pos  = !decision_ff[DW-1] && (decision_ff != '0);
      row_next = dec_pos ? row_ff + CW'(1) : row_ff;
      dec_mid  = dec_pos ? decision_ff + (DW'(row_next) <<< 1) + DW'(2) : decision_ff;
      dec_next = dec_mid + DW'({column_ff, 1'b1});
   end

   // Next state for start and step words
   always_comb begin
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      decision_in = decision_ff;
      running_in  = running_ff;
      if (take) begin
         if (action == mcpg_pkg::ACT_START) begin
            cx_in       = center_x;
            cy_in       = center_y;
            column_in   = '0;
            row_in      = -$signed(r_ext);
            decision_in = (r_ext == '0) ? '0 : DW'(1) - DW'(r_ext);
            running_in  = 1'b1;
         end else if (finish) begin
            running_in = 1'b0;
         end else begin
            row_in      = row_next;
            decision_in = dec_next;
            column_in   = column_ff + CW'(1);
         end
      end
   end

   // Hold walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff       <= '0;
         cy_ff       <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         decision_ff <= '0;
         running_ff  <= 1'b0;
      end else begin
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         decision_ff <= decision_in;
         running_ff  <= running_in;
      end
   end

   // Hand the step to the emitter
   assign job_ctl.load = take && (action == mcpg_pkg::ACT_STEP);
   assign job_ctl.done = finish;
   assign job_cx       = cx_ff;
   assign job_cy       = cy_ff;
   assign job_col      = column_ff;
   assign job_row      = row_next;

endmodule

FILE: rtl/mcpg_emit.sv
// Point emitter: holds one step job and sends its eight mirrored points,
// or one done word, through an output register. Depends on mcpg_pkg.
`timescale 1ns / 1ps

module mcpg_emit #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mcpg_pkg::job_ctl_type                   job_ctl,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    job_cx,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    job_cy,
   input  logic        [RADIUS_BITS:0]             job_col,
   input  logic signed [RADIUS_BITS:0]             job_row,
   output logic                                    can_load,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [mcpg_pkg::PIX_W-1:0]       rsp_pixel_x,
   output logic signed [mcpg_pkg::PIX_W-1:0]       rsp_pixel_y,
   output logic                                    rsp_point_valid,
   output logic                                    rsp_last,
   output logic                                    rsp_done_res
);

   localparam int CW = RADIUS_BITS + 1;
   localparam int AW = RADIUS_BITS + 2;

   logic                                 job_valid_ff;
   logic                                 job_done_ff;
   logic signed [mcpg_pkg::CENTER_W-1:0] cx_ff, cy_ff;
   logic        [CW-1:0]                 col_ff;
   logic signed [CW-1:0]                 row_ff;
   logic        [mcpg_pkg::IDX_W-1:0]    idx_ff;

   logic                              out_valid_ff;
   logic signed [mcpg_pkg::PIX_W-1:0] px_ff, py_ff, px_in, py_in;
   logic                              pv_ff, last_ff, done_ff;
   logic                              pv_in, last_in;

   logic                 out_free;
   logic                 word_last;
   logic signed [AW-1:0] col_s, row_s, a_sel, b_sel, a_val, b_val;

   // Build the current word from the job and the point index
   always_comb begin
      col_s     = $signed({1'b0, col_ff});
      row_s     = AW'(row_ff);
      a_sel     = idx_ff[2] ? row_s : col_s;
      b_sel     = idx_ff[2] ? col_s : row_s;
      a_val     = idx_ff[1] ? -a_sel : a_sel;
      b_val     = idx_ff[0] ? -b_sel : b_sel;
      word_last = job_done_ff || (idx_ff == mcpg_pkg::IDX_LAST);
      if (job_done_ff) begin
         px_in   = '0;
         py_in   = '0;
         pv_in   = 1'b0;
         last_in = 1'b1;
      end else begin
         px_in   = mcpg_pkg::PIX_W'(cx_ff) + mcpg_pkg::PIX_W'(a_val);
         py_in   = mcpg_pkg::PIX_W'(cy_ff) + mcpg_pkg::PIX_W'(b_val);
         pv_in   = 1'b1;
         last_in = (idx_ff == mcpg_pkg::IDX_LAST);
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign can_load = !job_valid_ff || (out_free && word_last);

   // Hold the job; advance the index as words leave
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (job_ctl.load) begin
         job_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (job_valid_ff && out_free) begin
         if (word_last) begin
            job_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + mcpg_pkg::IDX_W'(1);
         end
      end
   end

   // Job payload
   always_ff @(posedge clock) begin
      if (job_ctl.load) begin
         job_done_ff <= job_ctl.done;
         cx_ff       <= job_cx;
         cy_ff       <= job_cy;
         col_ff      <= job_col;
         row_ff      <= job_row;
      end
   end

   // Output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= job_valid_ff;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pv_ff   <= pv_in;
         last_ff <= last_in;
         done_ff <= job_done_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_point_valid = pv_ff;
   assign rsp_last        = last_ff;
   assign rsp_done_res    = done_ff;

endmodule

FILE: rtl/midpoint_circle_point_generator.sv
// Top level of the midpoint circle point generator: walk state and emitter.
// Depends on mcpg_pkg, mcpg_walk and mcpg_emit.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  action, center_x, center_y, radius
//   rsp_     out        rsp_valid/rsp_stall  pixel_x, pixel_y, point_valid, last, done_res
//
// A start word sends nothing. A step word sends eight points, one per cycle
// from the emitter's output register while rsp_stall is low; a step that
// finds the circle finished sends one done word.
// The next word is accepted at the edge where a step's final word enters
// the output register, so steps follow each other with no gap.
// Reset clears the walk state and both valid flags; rsp_stall holds the
// output word and, through the emitter, stalls the request side.
`timescale 1ns / 1ps

module midpoint_circle_point_generator #(
   parameter int RADIUS_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    req_center_x,
   input  logic signed [mcpg_pkg::CENTER_W-1:0]    req_center_y,
   input  logic        [RADIUS_BITS-1:0]           req_radius,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [mcpg_pkg::PIX_W-1:0]       rsp_pixel_x,
   output logic signed [mcpg_pkg::PIX_W-1:0]       rsp_pixel_y,
   output logic                                    rsp_point_valid,
   output logic                                    rsp_last,
   output logic                                    rsp_done_res
);

   mcpg_pkg::job_ctl_type                job_ctl;
   logic signed [mcpg_pkg::CENTER_W-1:0] job_cx, job_cy;
   logic        [RADIUS_BITS:0]          job_col;
   logic signed [RADIUS_BITS:0]          job_row;
   logic                                 can_load;
   logic                                 take;

   // Accept a word whenever the emitter can take its job
   assign req_stall = !can_load;
   assign take      = req_valid && can_load;

   mcpg_walk #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .action   (req_action),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .job_ctl  (job_ctl),
      .job_cx   (job_cx),
      .job_cy   (job_cy),
      .job_col  (job_col),
      .job_row  (job_row)
   );

   mcpg_emit #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .job_ctl         (job_ctl),
      .job_cx          (job_cx),
      .job_cy          (job_cy),
      .job_col         (job_col),
      .job_row         (job_row),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_point_valid (rsp_point_valid),
      .rsp_last        (rsp_last),
      .rsp_done_res    (rsp_done_res)
   );

endmodule

FILE: tb/tb.sv
// Self-checking bench for midpoint_circle_point_generator: table of directed words,
// then random circle walks, checked against an in-bench model of the octant walk.
// Depends on mcpg_pkg and the midpoint_circle_point_generator RTL.
`timescale 1ns / 1ps

module tb;

   localparam int CENTER_W    = mcpg_pkg::CENTER_W;
   localparam int PIX_W       = mcpg_pkg::PIX_W;
   localparam int RB          = 12;
   localparam int COORD_W     = RB + 1;
   localparam int COL_W       = RB + 2;
   localparam int DEC_W       = RB + 4;
   localparam int IDLE_PCT    = 10;
   localparam int HOLD_CYCLES = 160;
   localparam int RAND_WORDS  = 425;
   localparam int SHOW_MAX    = 10;

   typedef struct packed {
      logic signed [PIX_W-1:0] px;
      logic signed [PIX_W-1:0] py;
      logic                    pv;
      logic                    last;
      logic                    done;
   } pixel_word_type;

   typedef struct packed {
      logic                       act;
      logic signed [CENTER_W-1:0] cx;
      logic signed [CENTER_W-1:0] cy;
      logic        [RB-1:0]       rad;
      logic                       typed;
      pixel_word_type             word;
   } stim_row_type;

   localparam pixel_word_type DONE_WORD = '{px: '0, py: '0, pv: 1'b0, last: 1'b1, done: 1'b1};
   localparam pixel_word_type NO_WORD   = '0;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_action;
   logic signed [CENTER_W-1:0] req_center_x;
   logic signed [CENTER_W-1:0] req_center_y;
   logic        [RB-1:0]       req_radius;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [PIX_W-1:0]    rsp_pixel_x;
   logic signed [PIX_W-1:0]    rsp_pixel_y;
   logic                       rsp_point_valid;
   logic                       rsp_last;
   logic                       rsp_done_res;

   // circle walk model state
   int walk_cx, walk_cy, walk_col, walk_row, walk_dec;
   bit walk_on;

   pixel_word_type expected_pixels[$];

   int  mismatches  = 0;
   int  words_sent  = 0;
   int  starts_sent = 0;
   int  steps_sent  = 0;
   int  points_seen = 0;
   int  dones_seen  = 0;
   bit  quiet       = 1'b0;
   bit  hold_go     = 1'b0;
   bit  hold_taken  = 1'b0;
   int  hold_left   = 0;

   // directed words: reset, zero radius, unit radius, extremes, alternating bits
   stim_row_type dir_rows[23] = '{
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_STEP,  16'shffff, 16'shffff, 12'hfff, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_START, 16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh7fff, 16'sh8000, 12'hfff, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_START, 16'sd100,  -16'sd100, 12'h001, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_START, 16'sh7fff, 16'sh8000, 12'hfff, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh1234, 16'sh4321, 12'h123, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_START, 16'sh8000, 16'sh7fff, 12'hfff, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_START, 16'shffff, 16'shffff, 12'h002, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b1, DONE_WORD},
      '{mcpg_pkg::ACT_START, 16'sh5555, 16'shaaaa, 12'haaa, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'shaaaa, 16'sh5555, 12'h555, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_START, 16'sd10,   16'sd20,   12'h555, 1'b0, NO_WORD},
      '{mcpg_pkg::ACT_STEP,  16'sh0000, 16'sh0000, 12'h000, 1'b0, NO_WORD}
   };

   midpoint_circle_point_generator #(.RADIUS_BITS(RB)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_point_valid (rsp_point_valid),
      .rsp_last        (rsp_last),
      .rsp_done_res    (rsp_done_res)
   );

   // Fold a value into a signed field of the given width
   function automatic int wrap_bits(longint v, int bits);
      longint span, u;
      span = longint'(1) << bits;
      u = v & (span - 1);
      if (u >= (span >>> 1)) begin
         u = u - span;
      end
      return int'(u);
   endfunction

   function automatic void push_pixel(longint x, longint y, logic last_flag);
      pixel_word_type w;
      w.px   = x[PIX_W-1:0];
      w.py   = y[PIX_W-1:0];
      w.pv   = 1'b1;
      w.last = last_flag;
      w.done = 1'b0;
      expected_pixels.push_back(w);
   endfunction

   // Advance the octant walk by one word and queue the pixels it yields
   function automatic void advance_circle_walk(logic act, logic signed [CENTER_W-1:0] cx,
                                               logic signed [CENTER_W-1:0] cy,
                                               logic [RB-1:0] rad);
      int     rad_i;
      longint c, r, x, y;
      rad_i = rad;
      if (act == mcpg_pkg::ACT_START) begin
         walk_cx  = cx;
         walk_cy  = cy;
         walk_col = 0;
         walk_row = wrap_bits(-longint'(rad_i), COORD_W);
         walk_dec = (rad_i == 0) ? 0 : wrap_bits(1 - longint'(rad_i), DEC_W);
         walk_on  = 1'b1;
      end else if (!walk_on || !(walk_col < -walk_row)) begin
         walk_on = 1'b0;
         expected_pixels.push_back(DONE_WORD);
      end else begin
         if (walk_dec > 0) begin
            walk_row = wrap_bits(longint'(walk_row) + 1, COORD_W);
            walk_dec = wrap_bits(longint'(walk_dec) + 2 * longint'(walk_row) + 2, DEC_W);
         end
         walk_dec = wrap_bits(longint'(walk_dec) + 2 * longint'(walk_col) + 1, DEC_W);
         c = walk_col;
         r = walk_row;
         x = walk_cx;
         y = walk_cy;
         push_pixel(x + c, y + r, 1'b0);
         push_pixel(x + c, y - r, 1'b0);
         push_pixel(x - c, y + r, 1'b0);
         push_pixel(x - c, y - r, 1'b0);
         push_pixel(x + r, y + c, 1'b0);
         push_pixel(x + r, y - c, 1'b0);
         push_pixel(x - r, y + c, 1'b0);
         push_pixel(x - r, y - c, 1'b1);
         walk_col = wrap_bits(longint'(walk_col) + 1, COL_W);
      end
   endfunction

   // Offer one request word, hold it until taken, then queue its pixels
   task automatic send_word(input logic act, input logic signed [CENTER_W-1:0] cx,
                            input logic signed [CENTER_W-1:0] cy, input logic [RB-1:0] rad,
                            input logic typed, input pixel_word_type typed_word);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius   <= rad;
      do @(posedge clock); while (req_stall);
      advance_circle_walk(act, cx, cy, rad);
      // a typed row replaces the single computed word with its own value
      if (typed) begin
         expected_pixels[expected_pixels.size() - 1] = typed_word;
      end
      words_sent++;
      if (act == mcpg_pkg::ACT_START) starts_sent++;
      else steps_sent++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety limit on the whole run
   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   // Drive the result side stall: random idling, one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // Check each taken result word against the oldest expected word
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_point_valid) points_seen++;
         if (rsp_done_res) dones_seen++;
         if (expected_pixels.size() == 0) begin
            if (mismatches < SHOW_MAX) begin
               $display("mismatch at %0t: unexpected word x=%0d y=%0d pv=%0b last=%0b done=%0b",
                        $realtime, rsp_pixel_x, rsp_pixel_y, rsp_point_valid, rsp_last,
                        rsp_done_res);
            end
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.px || rsp_pixel_y !== want.py ||
                rsp_point_valid !== want.pv || rsp_last !== want.last ||
                rsp_done_res !== want.done) begin
               if (mismatches < SHOW_MAX) begin
                  $display("mismatch at %0t: want x=%0d y=%0d pv=%0b last=%0b done=%0b",
                           $realtime, want.px, want.py, want.pv, want.last, want.done);
                  $display("                  got  x=%0d y=%0d pv=%0b last=%0b done=%0b",
                           rsp_pixel_x, rsp_pixel_y, rsp_point_valid, rsp_last,
                           rsp_done_res);
               end
               mismatches++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random walks, drain
   initial begin
      int  rand_words;
      int  pick;
      int  nsteps;
      bit  paused;
      logic [RB-1:0] rad;
      walk_cx      = 0;
      walk_cy      = 0;
      walk_col     = 0;
      walk_row     = 0;
      walk_dec     = 0;
      walk_on      = 1'b0;
      rand_words   = 0;
      paused       = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = mcpg_pkg::ACT_START;
      req_center_x = '0;
      req_center_y = '0;
      req_radius   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].act, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].rad,
                   dir_rows[i].typed, dir_rows[i].word);
      end

      // random part: mostly full circle walks, some noise words
      while (rand_words < RAND_WORDS) begin
         quiet = (rand_words >= 180 && rand_words < 260);
         if (rand_words >= 100) hold_go = 1'b1;
         // let every expected word come back once with the request side quiet
         if (rand_words >= 300 && !paused) begin
            paused = 1'b1;
            @(negedge clock);
            req_valid <= 1'b0;
            while (expected_pixels.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            rad = ($urandom_range(0, 19) == 0) ? RB'($urandom_range(0, 4095))
                                               : RB'($urandom_range(0, 24));
            send_word(mcpg_pkg::ACT_START, CENTER_W'($urandom()), CENTER_W'($urandom()), rad,
                      1'b0, NO_WORD);
            rand_words++;
            nsteps = (rad > 24) ? $urandom_range(1, 6) : (rad * 3) / 4 + $urandom_range(1, 3);
            repeat (nsteps) begin
               send_word(mcpg_pkg::ACT_STEP, CENTER_W'($urandom()), CENTER_W'($urandom()),
                         RB'($urandom()), 1'b0, NO_WORD);
               rand_words++;
            end
         end else begin
            send_word(1'($urandom()), CENTER_W'($urandom()), CENTER_W'($urandom()),
                      RB'($urandom()), 1'b0, NO_WORD);
            rand_words++;
         end
      end
      quiet = 1'b0;

      // drain, then give stray words time to show up
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("run: %0d request words (%0d starts, %0d steps), %0d points, %0d done words",
               words_sent, starts_sent, steps_sent, points_seen, dones_seen);
      $display("run: long result hold-off %0s, %0d mismatching words",
               hold_taken ? "taken" : "missed", mismatches);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: midpoint_circle_point_generator.f
rtl/mcpg_pkg.sv
rtl/mcpg_walk.sv
rtl/mcpg_emit.sv
rtl/midpoint_circle_point_generator.sv
tb/tb.sv
